FILE: rtl/core/best_fit_span_allocator_macros.svh
// ----------------------------------------------------------------------------
// best_fit_span_allocator_macros.svh
// Assertion macros used by the allocator checker
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_SPAN_ALLOCATOR_MACROS_SVH
`define BEST_FIT_SPAN_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define BFSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bfsa_pkg.sv
// ----------------------------------------------------------------------------
// bfsa_pkg
// Shared sizes, codes and types of the best-fit span allocator
// ----------------------------------------------------------------------------
package bfsa_pkg;

  // table geometry
  localparam int SPAN_SLOTS = 64;
  localparam int SLOT_W     = $clog2(SPAN_SLOTS);
  localparam int CNT_W      = SLOT_W + 1;

  // field widths
  localparam int OFF_W   = 40;
  localparam int SIZE_W  = 32;
  localparam int ENTRY_W = OFF_W + SIZE_W;

  // request codes
  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } bfsa_func_e;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_ZERO = 2'd2,
    STATUS_DUP  = 2'd3
  } bfsa_status_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_RECHECK,
    ST_COMMIT,
    ST_DONE
  } bfsa_state_e;

  // compare unit flags for one table entry
  typedef struct packed {
    logic fits;
    logic same;
    logic better;
  } bfsa_cmp_t;

endpackage

FILE: rtl/core/bfsa_ram.sv
// ----------------------------------------------------------------------------
// bfsa_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module bfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/bfsa_cmp.sv
// ----------------------------------------------------------------------------
// bfsa_cmp
// Shared compare unit: rates one table entry against the key and the best
// ----------------------------------------------------------------------------
module bfsa_cmp (
  input  logic [bfsa_pkg::OFF_W-1:0]  cand_start_i,
  input  logic [bfsa_pkg::SIZE_W-1:0] cand_len_i,
  input  logic [bfsa_pkg::OFF_W-1:0]  key_start_i,
  input  logic [bfsa_pkg::SIZE_W-1:0] key_len_i,
  input  logic [bfsa_pkg::OFF_W-1:0]  best_start_i,
  input  logic [bfsa_pkg::SIZE_W-1:0] best_len_i,
  output bfsa_pkg::bfsa_cmp_t         flags_o
);

  // entry large enough for the request
  assign flags_o.fits   = (cand_len_i >= key_len_i);
  // entry equal to the key span
  assign flags_o.same   = (cand_start_i == key_start_i) && (cand_len_i == key_len_i);
  // smaller than the best so far, ties to the lower offset
  assign flags_o.better = (cand_len_i < best_len_i) ||
                          ((cand_len_i == best_len_i) && (cand_start_i < best_start_i));

endmodule

FILE: rtl/core/best_fit_span_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_span_allocator
// Best-fit free-span table with append fallback, one slot compared per cycle
// ----------------------------------------------------------------------------
//   channel   ports                                      handshake
//   config    file_end_base_we_i, file_end_base_i        write on we, no wait
//   request   func_i, span_offset_i, req_size_i          start_i && !busy_o
//   result    alloc_offset_o, reused_o, status_o         done_o, one cycle
//
// one slot read and compared per cycle; one pass over the table for a free,
// an append or an exact-fit allocate, a second pass (for a duplicate) when a
// remainder is kept, and no pass for a zero-size free
// busy_o stays high from accept until the done_o cycle ends
// reset clears the valid bits and append pointer at once, no clearing pass
// results cannot be stalled: done_o is a single-cycle strobe
// ----------------------------------------------------------------------------
module best_fit_span_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        file_end_base_we_i,
  input  logic [bfsa_pkg::OFF_W-1:0]  file_end_base_i,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        func_i,
  input  logic [bfsa_pkg::OFF_W-1:0]  span_offset_i,
  input  logic [bfsa_pkg::SIZE_W-1:0] req_size_i,
  output logic                        done_o,
  output logic [bfsa_pkg::OFF_W-1:0]  alloc_offset_o,
  output logic                        reused_o,
  output logic [1:0]                  status_o
);

  // sequencer and scan control
  bfsa_pkg::bfsa_state_e            state_q, state_d;
  logic [bfsa_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic                             chk_vld_q, chk_vld_d;
  logic [bfsa_pkg::SLOT_W-1:0]      chk_idx_q;
  logic [bfsa_pkg::SPAN_SLOTS-1:0]  used_q, used_d;
  logic [bfsa_pkg::OFF_W-1:0]       base_q, appended_q, appended_d;

  // request and search payload
  bfsa_pkg::bfsa_func_e             func_q, func_d;
  logic [bfsa_pkg::OFF_W-1:0]       key_start_q, key_start_d;
  logic [bfsa_pkg::SIZE_W-1:0]      key_len_q, key_len_d;
  logic                             best_found_q, best_found_d;
  logic [bfsa_pkg::SLOT_W-1:0]      best_idx_q, best_idx_d;
  logic [bfsa_pkg::OFF_W-1:0]       best_start_q, best_start_d;
  logic [bfsa_pkg::SIZE_W-1:0]      best_len_q, best_len_d;
  logic                             dup_q, dup_d;
  logic                             free_found_q, free_found_d;
  logic [bfsa_pkg::SLOT_W-1:0]      free_idx_q, free_idx_d;

  // result payload
  logic [bfsa_pkg::OFF_W-1:0]       res_offset_q, res_offset_d;
  logic                             res_reused_q, res_reused_d;
  bfsa_pkg::bfsa_status_e           res_status_q, res_status_d;

  // memory and compare unit
  logic                             issue;
  logic                             scan_end;
  logic                             accept;
  logic                             hit;
  logic [bfsa_pkg::SLOT_W-1:0]      rd_addr;
  logic                             ram_we;
  logic [bfsa_pkg::SLOT_W-1:0]      ram_waddr;
  logic [bfsa_pkg::ENTRY_W-1:0]     ram_wdata;
  logic [bfsa_pkg::ENTRY_W-1:0]     ram_rdata;
  logic [bfsa_pkg::OFF_W-1:0]       cand_start;
  logic [bfsa_pkg::SIZE_W-1:0]      cand_len;
  bfsa_pkg::bfsa_cmp_t              cmp;
  logic [bfsa_pkg::SIZE_W-1:0]      rest;
  logic [bfsa_pkg::OFF_W-1:0]       rest_start;

  // handshake and scan pointer
  assign accept   = start_i && (state_q == bfsa_pkg::ST_IDLE);
  assign issue    = (cnt_q < bfsa_pkg::CNT_W'(bfsa_pkg::SPAN_SLOTS));
  assign scan_end = !issue;
  assign rd_addr  = cnt_q[bfsa_pkg::SLOT_W-1:0];
  assign hit      = chk_vld_q && used_q[chk_idx_q];

  // remainder of the chosen span
  assign rest       = best_len_q - key_len_q;
  assign rest_start = best_start_q + bfsa_pkg::OFF_W'(key_len_q);

  // span table storage: {start, length}
  bfsa_ram #(
    .WIDTH (bfsa_pkg::ENTRY_W),
    .DEPTH (bfsa_pkg::SPAN_SLOTS)
  ) u_span_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign cand_start = ram_rdata[bfsa_pkg::ENTRY_W-1:bfsa_pkg::SIZE_W];
  assign cand_len   = ram_rdata[bfsa_pkg::SIZE_W-1:0];

  // one compare unit shared by both passes
  bfsa_cmp u_cmp (
    .cand_start_i (cand_start),
    .cand_len_i   (cand_len),
    .key_start_i  (key_start_q),
    .key_len_i    (key_len_q),
    .best_start_i (best_start_q),
    .best_len_i   (best_len_q),
    .flags_o      (cmp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfsa_pkg::ST_IDLE: begin
        if (accept) begin
          if ((func_i == bfsa_pkg::FUNC_FREE) && (req_size_i == '0)) begin
            state_d = bfsa_pkg::ST_DONE;
          end else begin
            state_d = bfsa_pkg::ST_SCAN;
          end
        end
      end
      bfsa_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = bfsa_pkg::ST_DECIDE;
        end
      end
      bfsa_pkg::ST_DECIDE: begin
        if ((func_q == bfsa_pkg::FUNC_ALLOC) && best_found_q && (rest != '0)) begin
          state_d = bfsa_pkg::ST_RECHECK;
        end else begin
          state_d = bfsa_pkg::ST_DONE;
        end
      end
      bfsa_pkg::ST_RECHECK: begin
        if (scan_end) begin
          state_d = bfsa_pkg::ST_COMMIT;
        end
      end
      bfsa_pkg::ST_COMMIT: state_d = bfsa_pkg::ST_DONE;
      bfsa_pkg::ST_DONE:   state_d = bfsa_pkg::ST_IDLE;
      default:             state_d = bfsa_pkg::ST_IDLE;
    endcase
  end

  // datapath and table updates per state
  always_comb begin
    cnt_d        = cnt_q;
    chk_vld_d    = 1'b0;
    used_d       = used_q;
    appended_d   = appended_q;
    func_d       = func_q;
    key_start_d  = key_start_q;
    key_len_d    = key_len_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    dup_d        = dup_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    res_offset_d = res_offset_q;
    res_reused_d = res_reused_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_waddr    = best_idx_q;
    ram_wdata    = {key_start_q, key_len_q};

    unique case (state_q)
      // latch the request and arm the scan
      bfsa_pkg::ST_IDLE: begin
        if (accept) begin
          func_d       = bfsa_pkg::bfsa_func_e'(func_i);
          key_start_d  = span_offset_i;
          key_len_d    = req_size_i;
          cnt_d        = '0;
          best_found_d = 1'b0;
          dup_d        = 1'b0;
          free_found_d = 1'b0;
          res_offset_d = '0;
          res_reused_d = 1'b0;
          res_status_d = bfsa_pkg::STATUS_ZERO;
        end
      end

      // first pass: best fit, or duplicate and first empty slot
      bfsa_pkg::ST_SCAN: begin
        if (issue) begin
          cnt_d     = cnt_q + 1'b1;
          chk_vld_d = 1'b1;
        end
        if (func_q == bfsa_pkg::FUNC_ALLOC) begin
          if (hit && cmp.fits && (!best_found_q || cmp.better)) begin
            best_found_d = 1'b1;
            best_idx_d   = chk_idx_q;
            best_start_d = cand_start;
            best_len_d   = cand_len;
          end
        end else begin
          if (hit && cmp.same) begin
            dup_d = 1'b1;
          end
          if (chk_vld_q && !used_q[chk_idx_q] && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = chk_idx_q;
          end
        end
      end

      // act on the first pass
      bfsa_pkg::ST_DECIDE: begin
        res_reused_d = 1'b0;
        res_status_d = bfsa_pkg::STATUS_OK;
        res_offset_d = '0;
        if (func_q == bfsa_pkg::FUNC_ALLOC) begin
          if (!best_found_q) begin
            // append at the end of the file
            res_offset_d = base_q + appended_q;
            appended_d   = appended_q + bfsa_pkg::OFF_W'(key_len_q);
          end else begin
            res_offset_d = best_start_q;
            res_reused_d = 1'b1;
            key_start_d  = rest_start;
            key_len_d    = rest;
            dup_d        = 1'b0;
            cnt_d        = '0;
            if (rest == '0) begin
              used_d[best_idx_q] = 1'b0;
            end
          end
        end else begin
          if (dup_q) begin
            res_status_d = bfsa_pkg::STATUS_DUP;
          end else if (!free_found_q) begin
            res_status_d = bfsa_pkg::STATUS_FULL;
          end else begin
            ram_we             = 1'b1;
            ram_waddr          = free_idx_q;
            used_d[free_idx_q] = 1'b1;
          end
        end
      end

      // second pass: is the remainder already in the table
      bfsa_pkg::ST_RECHECK: begin
        if (issue) begin
          cnt_d     = cnt_q + 1'b1;
          chk_vld_d = 1'b1;
        end
        if (hit && (chk_idx_q != best_idx_q) && cmp.same) begin
          dup_d = 1'b1;
        end
      end

      // shrink the chosen span, or drop it when the remainder exists
      bfsa_pkg::ST_COMMIT: begin
        if (dup_q) begin
          used_d[best_idx_q] = 1'b0;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = best_idx_q;
        end
      end

      bfsa_pkg::ST_DONE: begin
      end

      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bfsa_pkg::ST_IDLE;
      cnt_q      <= '0;
      chk_vld_q  <= 1'b0;
      used_q     <= '0;
      appended_q <= '0;
      base_q     <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      chk_vld_q  <= chk_vld_d;
      used_q     <= used_d;
      appended_q <= appended_d;
      if (file_end_base_we_i) begin
        base_q <= file_end_base_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    chk_idx_q    <= rd_addr;
    func_q       <= func_d;
    key_start_q  <= key_start_d;
    key_len_q    <= key_len_d;
    best_found_q <= best_found_d;
    best_idx_q   <= best_idx_d;
    best_start_q <= best_start_d;
    best_len_q   <= best_len_d;
    dup_q        <= dup_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    res_offset_q <= res_offset_d;
    res_reused_q <= res_reused_d;
    res_status_q <= res_status_d;
  end

  // ports
  assign busy_o         = (state_q != bfsa_pkg::ST_IDLE);
  assign done_o         = (state_q == bfsa_pkg::ST_DONE);
  assign alloc_offset_o = res_offset_q;
  assign reused_o       = res_reused_q;
  assign status_o       = res_status_q;

endmodule

FILE: rtl/core/bfsa_chk.sv
// ----------------------------------------------------------------------------
// bfsa_chk
// Port-level checks of the best-fit span allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "best_fit_span_allocator_macros.svh"

module bfsa_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        done_o,
  input logic [bfsa_pkg::OFF_W-1:0]  alloc_offset_o,
  input logic                        reused_o,
  input logic [1:0]                  status_o
);

  // an accepted item keeps the block busy
  `BFSA_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "accept did not raise busy")

  // the result strobe comes while busy and frees the block right after
  `BFSA_ASSERT_NOW(a_done_busy, done_o, busy_o, "result strobe while idle")
  `BFSA_ASSERT_NEXT(a_done_release, done_o, !busy_o && !done_o, "result not single or busy stuck")

  // a non-ok status only comes from a free, which grants nothing
  `BFSA_ASSERT_NOW(a_status_clean, done_o && (status_o != bfsa_pkg::STATUS_OK),
                   (alloc_offset_o == '0) && !reused_o, "free result carries a grant")

endmodule

bind best_fit_span_allocator bfsa_chk u_bfsa_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .alloc_offset_o (alloc_offset_o),
  .reused_o       (reused_o),
  .status_o       (status_o)
);

FILE: tb/sv/best_fit_span_allocator_tb.sv
// ----------------------------------------------------------------------------
// best_fit_span_allocator_tb
// Self-checking bench for the best-fit span allocator: a directed table
// (appends, exact fits, ties, duplicate remainders, address wrap, zero sizes)
// followed by random allocate/free traffic in several idling phases, each
// item scored against a free-span table kept inside the bench or its typed result.
// ----------------------------------------------------------------------------
module best_fit_span_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfsa_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int ITEMS_PER_PHASE = 350;

  typedef struct packed {
    bfsa_func_e        func;
    logic [OFF_W-1:0]  off;
    logic [SIZE_W-1:0] size;
  } span_req_t;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic             reused;
    bfsa_status_e     status;
  } grant_t;

  typedef struct packed {
    span_req_t req;
    logic      typed;
    grant_t    res;
  } dir_row_t;

  // dut ports
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              file_end_base_we_i = 1'b0;
  logic [OFF_W-1:0]  file_end_base_i = '0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic              func_i = 1'b0;
  logic [OFF_W-1:0]  span_offset_i = '0;
  logic [SIZE_W-1:0] req_size_i = '0;
  logic              done_o;
  logic [OFF_W-1:0]  alloc_offset_o;
  logic              reused_o;
  logic [1:0]        status_o;

  // free-span table as the bench sees it
  logic [OFF_W-1:0]  slot_off [SPAN_SLOTS];
  logic [SIZE_W-1:0] slot_len [SPAN_SLOTS];
  bit                slot_live [SPAN_SLOTS];
  logic [OFF_W-1:0]  tail_bytes = '0;
  logic [OFF_W-1:0]  open_len = '0;

  grant_t           pending_grants [$];
  logic [OFF_W-1:0] granted_offsets [$];
  grant_t           want;
  int               mismatches = 0;
  int               cycles = 0;

  // directed items, typed results only where obvious
  dir_row_t directed_rows [21] = '{
    '{'{FUNC_ALLOC, 40'd0, 32'd0}, 1'b1, '{40'd0, 1'b0, STATUS_OK}},
    '{'{FUNC_FREE, 40'd123, 32'd0}, 1'b1, '{40'd0, 1'b0, STATUS_ZERO}},
    '{'{FUNC_ALLOC, 40'd0, 32'd16}, 1'b1, '{40'd0, 1'b0, STATUS_OK}},
    '{'{FUNC_ALLOC, 40'd0, 32'hFFFF_FFFF}, 1'b1, '{40'd16, 1'b0, STATUS_OK}},
    '{'{FUNC_FREE, 40'd100, 32'd10}, 1'b1, '{40'd0, 1'b0, STATUS_OK}},
    '{'{FUNC_FREE, 40'd100, 32'd10}, 1'b1, '{40'd0, 1'b0, STATUS_DUP}},
    '{'{FUNC_FREE, 40'd107, 32'd3}, 1'b1, '{40'd0, 1'b0, STATUS_OK}},
    '{'{FUNC_ALLOC, 40'd0, 32'd7}, 1'b1, '{40'd100, 1'b1, STATUS_OK}},
    '{'{FUNC_ALLOC, 40'd0, 32'd3}, 1'b1, '{40'd107, 1'b1, STATUS_OK}},
    '{'{FUNC_ALLOC, 40'd0, 32'd3}, 1'b1, '{40'h1_0000_000F, 1'b0, STATUS_OK}},
    '{'{FUNC_FREE, 40'd500, 32'd8}, 1'b0, '{40'd0, 1'b0, STATUS_OK}},
    '{'{FUNC_FREE, 40'd300, 32'd8}, 1'b0, '{40'd0, 1'b0, STATUS_OK}},
    '{'{FUNC_ALLOC, 40'd0, 32'd8}, 1'b0, '{40'd0, 1'b0, STATUS_OK}},
    '{'{FUNC_ALLOC, 40'hFF_FFFF_FFFF, 32'd0}, 1'b0, '{40'd0, 1'b0, STATUS_OK}},
    '{'{FUNC_FREE, 40'hFF_FFFF_FFFC, 32'd10}, 1'b0, '{40'd0, 1'b0, STATUS_OK}},
    '{'{FUNC_ALLOC, 40'd0, 32'd9}, 1'b0, '{40'd0, 1'b0, STATUS_OK}},
    '{'{FUNC_ALLOC, 40'd0, 32'd1}, 1'b0, '{40'd0, 1'b0, STATUS_OK}},
    '{'{FUNC_FREE, 40'd0, 32'hFFFF_FFFF}, 1'b0, '{40'd0, 1'b0, STATUS_OK}},
    '{'{FUNC_FREE, 40'hFF_FFFF_FFFF, 32'd1}, 1'b0, '{40'd0, 1'b0, STATUS_OK}},
    '{'{FUNC_ALLOC, 40'd0, 32'hFFFF_FFFF}, 1'b0, '{40'd0, 1'b0, STATUS_OK}},
    '{'{FUNC_ALLOC, 40'd0, 32'd2}, 1'b0, '{40'd0, 1'b0, STATUS_OK}}
  };

  best_fit_span_allocator uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .file_end_base_we_i (file_end_base_we_i),
    .file_end_base_i    (file_end_base_i),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .func_i             (func_i),
    .span_offset_i      (span_offset_i),
    .req_size_i         (req_size_i),
    .done_o             (done_o),
    .alloc_offset_o     (alloc_offset_o),
    .reused_o           (reused_o),
    .status_o           (status_o)
  );

  always #6 clk_i = ~clk_i;

  // live slot holding exactly this span, ignoring one slot
  function automatic int find_span(input logic [OFF_W-1:0] off,
                                   input logic [SIZE_W-1:0] len, input int skip);
    for (int k = 0; k < SPAN_SLOTS; k++) begin
      if (k != skip && slot_live[k] && slot_off[k] == off && slot_len[k] == len)
        return k;
    end
    return -1;
  endfunction

  // grant or insert one item and update the span table
  function automatic grant_t span_table_step(input span_req_t r);
    grant_t            g;
    int                best;
    logic [SIZE_W-1:0] rest;
    logic [OFF_W-1:0]  rest_off;
    g = '{'0, 1'b0, STATUS_OK};
    if (r.func == FUNC_ALLOC) begin
      best = -1;
      for (int k = 0; k < SPAN_SLOTS; k++) begin
        if (slot_live[k] && slot_len[k] >= r.size) begin
          if (best < 0 || slot_len[k] < slot_len[best] ||
              (slot_len[k] == slot_len[best] && slot_off[k] < slot_off[best]))
            best = k;
        end
      end
      if (best >= 0) begin
        rest     = slot_len[best] - r.size;
        rest_off = slot_off[best] + OFF_W'(r.size);
        g.offset = slot_off[best];
        g.reused = 1'b1;
        // remainder dropped when empty or already present
        if (rest == '0 || find_span(rest_off, rest, best) >= 0) begin
          slot_live[best] = 1'b0;
        end else begin
          slot_off[best] = rest_off;
          slot_len[best] = rest;
        end
      end else begin
        g.offset   = open_len + tail_bytes;
        tail_bytes = tail_bytes + OFF_W'(r.size);
      end
    end else if (r.size == '0) begin
      g.status = STATUS_ZERO;
    end else if (find_span(r.off, r.size, -1) >= 0) begin
      g.status = STATUS_DUP;
    end else begin
      g.status = STATUS_FULL;
      for (int k = 0; k < SPAN_SLOTS; k++) begin
        if (!slot_live[k]) begin
          slot_live[k] = 1'b1;
          slot_off[k]  = r.off;
          slot_len[k]  = r.size;
          g.status     = STATUS_OK;
          break;
        end
      end
    end
    return g;
  endfunction

  // random live slot, or -1 when the table is empty
  function automatic int any_live_slot();
    int live_cnt;
    int pick;
    live_cnt = 0;
    for (int k = 0; k < SPAN_SLOTS; k++)
      if (slot_live[k]) live_cnt++;
    if (live_cnt == 0) return -1;
    pick = $urandom_range(live_cnt - 1);
    for (int k = 0; k < SPAN_SLOTS; k++) begin
      if (slot_live[k]) begin
        if (pick == 0) return k;
        pick--;
      end
    end
    return -1;
  endfunction

  // mostly spans that interact with the table, some noise
  function automatic span_req_t random_request(input int free_pct);
    span_req_t r;
    int        s;
    int        pick;
    s = any_live_slot();
    pick = $urandom_range(99);
    r.off[31:0]  = $urandom;
    r.off[39:32] = $urandom_range(255);
    r.size = $urandom;
    if ($urandom_range(99) < free_pct) begin
      r.func = FUNC_FREE;
      if (pick < 5) begin
        r.size = '0;
      end else if (pick < 20 && s >= 0) begin
        r.off  = slot_off[s];
        r.size = slot_len[s];
      end else if (pick < 45 && granted_offsets.size() != 0) begin
        r.off  = granted_offsets[$urandom_range(granted_offsets.size() - 1)];
        r.size = $urandom_range(64, 1);
      end else if (pick < 55) begin
        if ($urandom_range(1)) r.off = '1;
        else r.off = '0;
        r.size = $urandom_range(16, 1);
      end else if (pick < 90) begin
        r.off  = $urandom_range(4095);
        r.size = $urandom_range(64, 1);
      end
    end else begin
      r.func = FUNC_ALLOC;
      if (pick < 35 && s >= 0) r.size = slot_len[s];
      else if (pick < 55 && s >= 0)
        r.size = (slot_len[s] > 3) ? slot_len[s] - $urandom_range(3, 1) : '0;
      else if (pick < 75) r.size = $urandom_range(64);
      else if (pick < 85) r.size = '0;
      else if (pick < 95) r.size = $urandom;
      else r.size = '1;
    end
    return r;
  endfunction

  // present one item, wait for acceptance, log its result
  task automatic send_request(input span_req_t r, input int gap, input logic typed,
                              input grant_t typed_res);
    grant_t g;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    func_i        <= r.func;
    span_offset_i <= r.off;
    req_size_i    <= r.size;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    g = span_table_step(r);
    pending_grants.insert(pending_grants.size(), typed ? typed_res : g);
    if (r.func == FUNC_ALLOC) begin
      granted_offsets.insert(granted_offsets.size(), g.offset);
      if (granted_offsets.size() > 64) void'(granted_offsets.pop_front());
    end
  endtask

  // let the block drain before touching the register
  task automatic drain();
    start_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_file_end(input logic [OFF_W-1:0] v);
    file_end_base_we_i <= 1'b1;
    file_end_base_i    <= v;
    @(posedge clk_i);
    file_end_base_we_i <= 1'b0;
    open_len = v;
  endtask

  // main sequence
  initial begin
    int               idle_pct;
    int               bias;
    int               gap;
    logic [OFF_W-1:0] base;
    for (int k = 0; k < SPAN_SLOTS; k++) slot_live[k] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, 0, directed_rows[i].typed, directed_rows[i].res);

    bias = 50;
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: base = '1;
        1: begin
          base[31:0]  = $urandom;
          base[39:32] = $urandom_range(255);
        end
        2: base = '0;
        default: base = 40'hFF_FFFF_F000;
      endcase
      load_file_end(base);
      case (phase)
        1: idle_pct = 70;
        3: idle_pct = 11;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // free-heavy stretches fill the table, alloc-heavy ones drain it
        if (n % 40 == 0) begin
          case ($urandom_range(2))
            0: bias = 25;
            1: bias = 50;
            default: bias = 85;
          endcase
        end
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(150, 1) : 0;
        send_request(random_request(bias), gap, 1'b0, '0);
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("best_fit_span_allocator_tb OK");
    end else begin
      $display("best_fit_span_allocator_tb NOT OK");
    end
    $finish;
  end

  // score each result strobe against the oldest pending grant
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_grants.size() == 0) begin
        $error("result with no item pending");
        mismatches++;
      end else begin
        want = pending_grants.pop_front();
        if (alloc_offset_o !== want.offset) begin
          $error("alloc_offset: expected %h, got %h", want.offset, alloc_offset_o);
          mismatches++;
        end
        if (reused_o !== want.reused) begin
          $error("reused: expected %b, got %b", want.reused, reused_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("best_fit_span_allocator_tb NOT OK");
      $finish;
    end
  end

endmodule
